// File: hw/rtl/pnse_pkg.sv
// Shared types and constants of the Petri net step engine.
`default_nettype none

package pnse_pkg;

	// Net size and token width
	localparam int NUM_PLACES = 14;
	localparam int NUM_TRANS  = 14;
	localparam int TOKEN_BITS = 8;

	localparam int PIDX_W = $clog2(NUM_PLACES);
	localparam int TIDX_W = $clog2(NUM_TRANS);
	localparam int CNT_W  = $clog2(NUM_TRANS + 1);

	localparam logic [TOKEN_BITS-1:0] TOKEN_MAX = {TOKEN_BITS{1'b1}};

	// Command codes
	typedef enum logic [2:0] {
		CMD_WR_IN  = 3'd0,
		CMD_WR_OUT = 3'd1,
		CMD_SET    = 3'd2,
		CMD_STEP   = 3'd3,
		CMD_READ   = 3'd4
	} cmd_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONS,
		ST_PROD,
		ST_RESP
	} state_t;

	// One arc: present mark and weight
	typedef struct packed {
		logic                  pres;
		logic [TOKEN_BITS-1:0] w;
	} arc_t;

	typedef arc_t [NUM_PLACES-1:0] arc_row_t;

	// Input beat
	typedef struct packed {
		logic [2:0] cmd;
		logic [3:0] trans_index;
		logic [3:0] place_index;
		logic [7:0] value;
		logic       present;
	} item_t;

	// Result beat
	typedef struct packed {
		logic [7:0] tokens;
		logic       place_exists;
		logic       fired;
		logic       saturated;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/petri_net_step_engine.sv
// Top level of the Petri net step engine: arc memories, place lanes, step sequencer.
`default_nettype none

// Petri net step engine. A beat is taken when start is high and busy is low;
// exactly one result beat follows, shown for one cycle with done high, and
// the receiver cannot stall it. Arc writes, place sets and reads go from
// accept to the response state and back to idle. A step keeps the block
// busy for a consume pass, a produce pass and a response: the sequencer walks
// the input-arc memory one transition row per cycle for the consume pass,
// then the output-arc memory one row per cycle for the produce pass, each
// pass reading its rows through a registered stage, then enters the response state.
// The row memories have one read port, which sets the one-row-per-cycle pace;
// consume lanes compare and subtract, and separate produce lanes add, for all places of a row.
// The arc memories need no clearing pass: each row carries a valid bit that
// reset clears, and an unwritten row reads as zero.
module petri_net_step_engine (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire pnse_pkg::item_t item,
	output logic             busy,
	output logic             done,
	output pnse_pkg::result_t result
);
	import pnse_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;
	logic              cnt_end;
	logic              issue;
	logic [TIDX_W-1:0] rd_addr;

	logic              accept;
	logic              tok, pok;
	logic [TIDX_W-1:0] tidx;
	logic [PIDX_W-1:0] pidx;
	arc_t              wr_arc;
	logic              wr_in, wr_out, wr_set, is_step;

	// Arc memories and row valid bits
	arc_row_t          in_arc_mem  [NUM_TRANS];
	arc_row_t          out_arc_mem [NUM_TRANS];
	logic [NUM_TRANS-1:0] in_row_vld_q, out_row_vld_q;

	// Read stage
	arc_row_t          in_row_s1, out_row_s1;
	logic              in_vld_s1, out_vld_s1;
	logic              valid_s1;
	logic [TIDX_W-1:0] t_s1;

	// Places
	logic [TOKEN_BITS-1:0] place_tokens_q  [NUM_PLACES];
	logic [NUM_PLACES-1:0] place_present_q;

	// Step bookkeeping
	logic [NUM_TRANS-1:0] fires_q;
	logic                 fired_q, sat_q;
	logic [PIDX_W-1:0]    pidx_q;
	logic                 pok_q;

	// Lane results
	arc_row_t              cons_row, prod_row;
	logic [NUM_PLACES-1:0] counted, short_p, prod_hit, prod_clip;
	logic                  enable;
	logic [TOKEN_BITS-1:0] cons_nxt [NUM_PLACES];
	logic [TOKEN_BITS-1:0] prod_nxt [NUM_PLACES];
	logic [TOKEN_BITS:0]   prod_sum [NUM_PLACES];
	logic                  do_cons, do_prod;

	// Input decode
	assign accept = start && (state_q == ST_IDLE);
	assign tok    = int'(item.trans_index) < NUM_TRANS;
	assign pok    = int'(item.place_index) < NUM_PLACES;
	assign tidx   = TIDX_W'(item.trans_index);
	assign pidx   = PIDX_W'(item.place_index);
	assign wr_arc = '{pres: item.present, w: TOKEN_BITS'(item.value)};

	always_comb begin
		wr_in   = 1'b0;
		wr_out  = 1'b0;
		wr_set  = 1'b0;
		is_step = 1'b0;
		unique case (item.cmd)
			CMD_WR_IN:  wr_in   = accept && tok && pok;
			CMD_WR_OUT: wr_out  = accept && tok && pok;
			CMD_SET:    wr_set  = accept && pok;
			CMD_STEP:   is_step = accept;
			default:    ;
		endcase
	end

	// Sequencer counter
	assign cnt_end = cnt_q == CNT_W'(NUM_TRANS);
	assign issue   = ((state_q == ST_CONS) || (state_q == ST_PROD)) && !cnt_end;
	assign rd_addr = cnt_q[TIDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = is_step ? ST_CONS : ST_RESP;
			end
			ST_CONS: begin
				if (cnt_end) state_d = ST_PROD;
			end
			ST_PROD: begin
				if (cnt_end) state_d = ST_RESP;
			end
			ST_RESP: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Outputs
	always_comb begin
		busy                = state_q != ST_IDLE;
		done                = state_q == ST_RESP;
		result.tokens       = pok_q ? 8'(place_tokens_q[pidx_q]) : 8'd0;
		result.place_exists = pok_q && place_present_q[pidx_q];
		result.fired        = fired_q;
		result.saturated    = sat_q;
	end

	// Arc memories: masked write, whole row zeroed on first write
	always_ff @(posedge clk) begin
		for (int p = 0; p < NUM_PLACES; p++) begin
			if (wr_in) begin
				if (p == int'(pidx)) in_arc_mem[tidx][p] <= wr_arc;
				else if (!in_row_vld_q[tidx]) in_arc_mem[tidx][p] <= '0;
			end
			if (wr_out) begin
				if (p == int'(pidx)) out_arc_mem[tidx][p] <= wr_arc;
				else if (!out_row_vld_q[tidx]) out_arc_mem[tidx][p] <= '0;
			end
		end
		in_row_s1  <= in_arc_mem[rd_addr];
		out_row_s1 <= out_arc_mem[rd_addr];
		in_vld_s1  <= in_row_vld_q[rd_addr];
		out_vld_s1 <= out_row_vld_q[rd_addr];
		t_s1       <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_vld_q  <= '0;
			out_row_vld_q <= '0;
			valid_s1      <= 1'b0;
		end else begin
			if (wr_in)  in_row_vld_q[tidx]  <= 1'b1;
			if (wr_out) out_row_vld_q[tidx] <= 1'b1;
			valid_s1 <= issue;
		end
	end

	// Consume lanes: enable check and subtract
	always_comb begin
		cons_row = in_vld_s1 ? in_row_s1 : '0;
		for (int p = 0; p < NUM_PLACES; p++) begin
			counted[p]  = place_present_q[p] && cons_row[p].pres;
			short_p[p]  = counted[p] && (place_tokens_q[p] < cons_row[p].w);
			cons_nxt[p] = counted[p] ? place_tokens_q[p] - cons_row[p].w
			                         : place_tokens_q[p];
		end
		enable = (|counted) && !(|short_p);
	end

	// Produce lanes: saturating add
	always_comb begin
		prod_row = out_vld_s1 ? out_row_s1 : '0;
		for (int p = 0; p < NUM_PLACES; p++) begin
			prod_hit[p]  = place_present_q[p] && prod_row[p].pres;
			prod_sum[p]  = {1'b0, place_tokens_q[p]} + {1'b0, prod_row[p].w};
			prod_clip[p] = prod_hit[p] && prod_sum[p][TOKEN_BITS];
			if (!prod_hit[p]) prod_nxt[p] = place_tokens_q[p];
			else if (prod_sum[p][TOKEN_BITS]) prod_nxt[p] = TOKEN_MAX;
			else prod_nxt[p] = prod_sum[p][TOKEN_BITS-1:0];
		end
	end

	assign do_cons = valid_s1 && (state_q == ST_CONS) && enable;
	assign do_prod = valid_s1 && (state_q == ST_PROD) && fires_q[t_s1];

	// Place registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLACES; p++) place_tokens_q[p] <= '0;
			place_present_q <= '0;
		end else if (wr_set) begin
			place_tokens_q[pidx]  <= TOKEN_BITS'(item.value);
			place_present_q[pidx] <= item.present;
		end else if (do_cons) begin
			for (int p = 0; p < NUM_PLACES; p++) place_tokens_q[p] <= cons_nxt[p];
		end else if (do_prod) begin
			for (int p = 0; p < NUM_PLACES; p++) place_tokens_q[p] <= prod_nxt[p];
		end
	end

	// Step flags and response address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fires_q <= '0;
			fired_q <= 1'b0;
			sat_q   <= 1'b0;
			pidx_q  <= '0;
			pok_q   <= 1'b0;
		end else if (accept) begin
			fires_q <= '0;
			fired_q <= 1'b0;
			sat_q   <= 1'b0;
			pidx_q  <= pidx;
			pok_q   <= pok;
		end else begin
			if (do_cons) begin
				fires_q[t_s1] <= 1'b1;
				fired_q       <= 1'b1;
			end
			if (do_prod && (|prod_clip)) sat_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/pnse_checker.sv
// Port-level checks of the Petri net step engine and their bind.
`default_nettype none

module pnse_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               start,
	input wire pnse_pkg::item_t   item,
	input wire               busy,
	input wire               done,
	input wire pnse_pkg::result_t result
);
	import pnse_pkg::*;

	// A result beat only while an item is held
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat while idle");

	// An accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accept did not raise busy");

	// A result beat is never followed directly by another
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat repeated");

	// Busy drops only right after the result beat
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("item finished without a result beat");

endmodule

bind petri_net_step_engine pnse_checker u_pnse_checker (.*);

`default_nettype wire

// File: sim/pnse_scoreboard.sv
// Scoreboard package: firing-step predictor and result checker for the step engine bench.
`timescale 1ns / 1ps

package pnse_tb_pkg;

	import pnse_pkg::*;

	// Command codes the block leaves unused; they behave as a read
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	// Largest value a 4-bit index field can carry
	localparam int IDX_TOP = 15;

	class firing_scoreboard;

		// Predicted net state
		logic [TOKEN_BITS-1:0] marking  [NUM_PLACES];
		bit                    place_on [NUM_PLACES];
		arc_t                  in_arcs  [NUM_TRANS][NUM_PLACES];
		arc_t                  out_arcs [NUM_TRANS][NUM_PLACES];

		result_t expected_results[$];

		int errors;
		int items_seen;
		int steps_seen;
		int live_steps;
		int clipped_steps;

		function new();
			for (int p = 0; p < NUM_PLACES; p++) begin
				marking[p]  = '0;
				place_on[p] = 1'b0;
			end
			for (int t = 0; t < NUM_TRANS; t++) begin
				for (int p = 0; p < NUM_PLACES; p++) begin
					in_arcs[t][p]  = '0;
					out_arcs[t][p] = '0;
				end
			end
			errors        = 0;
			items_seen    = 0;
			steps_seen    = 0;
			live_steps    = 0;
			clipped_steps = 0;
		endfunction

		// One firing step: consume in index order, then produce for the fired ones
		function void fire_net(output bit any_fired, output bit any_clip);
			bit fires [NUM_TRANS];
			int counted;
			bit ok;
			int sum;
			any_fired = 1'b0;
			any_clip  = 1'b0;
			for (int t = 0; t < NUM_TRANS; t++) begin
				counted  = 0;
				ok       = 1'b1;
				fires[t] = 1'b0;
				for (int p = 0; p < NUM_PLACES; p++) begin
					if (place_on[p] && in_arcs[t][p].pres) begin
						counted++;
						if (marking[p] < in_arcs[t][p].w)
							ok = 1'b0;
					end
				end
				if (ok && counted != 0) begin
					for (int p = 0; p < NUM_PLACES; p++) begin
						if (place_on[p] && in_arcs[t][p].pres)
							marking[p] = marking[p] - in_arcs[t][p].w;
					end
					fires[t]  = 1'b1;
					any_fired = 1'b1;
				end
			end
			for (int t = 0; t < NUM_TRANS; t++) begin
				if (fires[t]) begin
					for (int p = 0; p < NUM_PLACES; p++) begin
						if (place_on[p] && out_arcs[t][p].pres) begin
							sum = int'(marking[p]) + int'(out_arcs[t][p].w);
							if (sum > int'(TOKEN_MAX)) begin
								sum      = int'(TOKEN_MAX);
								any_clip = 1'b1;
							end
							marking[p] = sum[TOKEN_BITS-1:0];
						end
					end
				end
			end
		endfunction

		// Apply one beat to the predicted net and return the result it should give
		function result_t predict_result(item_t it);
			result_t r;
			bit t_ok;
			bit p_ok;
			bit fired;
			bit clip;
			arc_t arc;
			t_ok   = int'(it.trans_index) < NUM_TRANS;
			p_ok   = int'(it.place_index) < NUM_PLACES;
			fired  = 1'b0;
			clip   = 1'b0;
			arc.pres = it.present;
			arc.w    = it.value[TOKEN_BITS-1:0];
			case (it.cmd)
				CMD_WR_IN: begin
					if (t_ok && p_ok)
						in_arcs[it.trans_index][it.place_index] = arc;
				end
				CMD_WR_OUT: begin
					if (t_ok && p_ok)
						out_arcs[it.trans_index][it.place_index] = arc;
				end
				CMD_SET: begin
					if (p_ok) begin
						marking[it.place_index]  = it.value[TOKEN_BITS-1:0];
						place_on[it.place_index] = it.present;
					end
				end
				CMD_STEP: begin
					fire_net(fired, clip);
					steps_seen++;
					if (fired)
						live_steps++;
					if (clip)
						clipped_steps++;
				end
				default: ;
			endcase
			r.tokens       = p_ok ? 8'(marking[it.place_index]) : 8'd0;
			r.place_exists = p_ok ? place_on[it.place_index] : 1'b0;
			r.fired        = fired;
			r.saturated    = clip;
			return r;
		endfunction

		// Accepted input beat: queue what it must produce
		function void take_item(item_t it);
			items_seen++;
			expected_results.push_back(predict_result(it));
		endfunction

		// Result beat: compare with the oldest expectation, field by field
		function void check_result(result_t got);
			result_t exp;
			bit bad;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				errors++;
				return;
			end
			exp = expected_results.pop_front();
			bad = 1'b0;
			if (got.tokens !== exp.tokens) begin
				$display("%0t: tokens expected %0d, got %0d", $time, exp.tokens, got.tokens);
				bad = 1'b1;
			end
			if (got.place_exists !== exp.place_exists) begin
				$display("%0t: place_exists expected %b, got %b", $time,
					exp.place_exists, got.place_exists);
				bad = 1'b1;
			end
			if (got.fired !== exp.fired) begin
				$display("%0t: fired expected %b, got %b", $time, exp.fired, got.fired);
				bad = 1'b1;
			end
			if (got.saturated !== exp.saturated) begin
				$display("%0t: saturated expected %b, got %b", $time,
					exp.saturated, got.saturated);
				bad = 1'b1;
			end
			if (bad)
				errors++;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Whatever is still queued at the end never arrived
		function void flag_missing();
			result_t exp;
			while (expected_results.size() != 0) begin
				exp = expected_results.pop_front();
				$display("%0t: missing result, expected %h, got none", $time, exp);
				errors++;
			end
		endfunction

	endclass

endpackage

// File: sim/petri_net_step_engine_test.sv
// Bench top: drives directed and random command beats into the step engine and checks results.
`timescale 1ns / 1ps

module petri_net_step_engine_test;

	import pnse_pkg::*;
	import pnse_tb_pkg::*;

	localparam int TOTAL_ITEMS = 1350;
	localparam int QUIET_TAIL  = 150;
	localparam int DRAIN_LIMIT = 2000;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	firing_scoreboard sb;
	int idle_odds;

	petri_net_step_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result monitor: a beat is taken at the edge that ends its cycle
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// Safety net against a hung handshake
	initial begin
		#5_000_000;
		$display("petri_net_step_engine: mismatch");
		$finish;
	end

	function automatic item_t make_beat(logic [2:0] c, int unsigned t, int unsigned p,
			int unsigned v, int unsigned pr);
		item_t b;
		b.cmd         = c;
		b.trans_index = t[3:0];
		b.place_index = p[3:0];
		b.value       = v[7:0];
		b.present     = pr[0];
		return b;
	endfunction

	// Present a beat and hold it until the block takes it
	task automatic send_beat(item_t b);
		start <= 1'b1;
		item  <= b;
		do @(posedge clk); while (busy);
		sb.take_item(b);
		// random idle burst after the beat
		if (idle_odds != 0 && $urandom_range(0, 3) < idle_odds) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// Arc weights mostly small so nets stay live, sometimes anything
	function automatic int unsigned pick_weight();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
	endfunction

	// Token counts: mostly small, some near the top to provoke clipping
	function automatic int unsigned pick_tokens();
		int unsigned r;
		r = $urandom_range(0, 4);
		if (r < 3)
			return $urandom_range(0, 8);
		else if (r == 3)
			return $urandom_range(240, 255);
		return $urandom_range(0, 255);
	endfunction

	function automatic int unsigned pick_present();
		return ($urandom_range(0, 7) != 0) ? 1 : 0;
	endfunction

	// Step beat with its ignored fields scrambled
	function automatic item_t step_beat();
		return make_beat(CMD_STEP, $urandom_range(0, IDX_TOP),
			$urandom_range(0, NUM_PLACES - 1), $urandom_range(0, 255), $urandom_range(0, 1));
	endfunction

	// Build a bit of net, mark some places, then run steps with reads in between
	task automatic run_scenario();
		int n;
		n = $urandom_range(2, 10);
		repeat (n) begin
			send_beat(make_beat(($urandom_range(0, 1) == 0) ? CMD_WR_IN : CMD_WR_OUT,
				$urandom_range(0, NUM_TRANS - 1), $urandom_range(0, NUM_PLACES - 1),
				pick_weight(), pick_present()));
		end
		n = $urandom_range(1, 6);
		repeat (n) begin
			send_beat(make_beat(CMD_SET, $urandom_range(0, IDX_TOP),
				$urandom_range(0, NUM_PLACES - 1), pick_tokens(), pick_present()));
		end
		n = $urandom_range(1, 6);
		repeat (n) begin
			send_beat(step_beat());
			if ($urandom_range(0, 2) == 0)
				send_beat(make_beat(CMD_READ, $urandom_range(0, IDX_TOP),
					$urandom_range(0, NUM_PLACES - 1), $urandom_range(0, 255),
					$urandom_range(0, 1)));
		end
	endtask

	// Anything the fields can carry, unused codes and bad indexes included
	task automatic run_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) begin
			send_beat(make_beat(3'($urandom_range(0, CMD_SPARE_LAST)),
				$urandom_range(0, IDX_TOP), $urandom_range(0, IDX_TOP),
				$urandom_range(0, 255), $urandom_range(0, 1)));
		end
	endtask

	initial begin
		int guard;
		sb = new();
		idle_odds = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset state, dead empty net
		idle_odds = 1;
		send_beat(make_beat(CMD_READ, 0, 0, 0, 0));
		send_beat(make_beat(CMD_STEP, 0, 0, 0, 0));
		// full-weight transfer T1: P1 -> P2, then a second one that clips
		send_beat(make_beat(CMD_SET, 0, 0, 255, 1));
		send_beat(make_beat(CMD_SET, 0, 1, 0, 1));
		send_beat(make_beat(CMD_WR_IN, 0, 0, 255, 1));
		send_beat(make_beat(CMD_WR_OUT, 0, 1, 255, 1));
		send_beat(make_beat(CMD_STEP, 0, 1, 0, 0));
		send_beat(make_beat(CMD_SET, 0, 0, 255, 1));
		send_beat(make_beat(CMD_STEP, 0, 1, 0, 0));
		// zero-weight input arc is met by an empty place
		send_beat(make_beat(CMD_WR_IN, 13, 13, 0, 1));
		send_beat(make_beat(CMD_SET, 0, 13, 0, 1));
		send_beat(make_beat(CMD_STEP, 13, 13, 0, 0));
		// conflict on one token: lower index wins
		send_beat(make_beat(CMD_SET, 0, 2, 1, 1));
		send_beat(make_beat(CMD_WR_IN, 1, 2, 1, 1));
		send_beat(make_beat(CMD_WR_IN, 2, 2, 1, 1));
		send_beat(make_beat(CMD_STEP, 15, 2, 255, 1));
		// removed place and removed arc keep values but drop out; net goes dead
		send_beat(make_beat(CMD_SET, 0, 13, 0, 0));
		send_beat(make_beat(CMD_WR_IN, 0, 0, 255, 0));
		send_beat(make_beat(CMD_STEP, 0, 2, 0, 0));
		send_beat(make_beat(CMD_READ, 0, 13, 0, 0));
		// out-of-range indexes
		send_beat(make_beat(CMD_WR_IN, 14, 0, 9, 1));
		send_beat(make_beat(CMD_WR_OUT, IDX_TOP, IDX_TOP, 255, 1));
		send_beat(make_beat(CMD_SET, 0, 14, 7, 1));
		send_beat(make_beat(CMD_READ, 0, IDX_TOP, 0, 0));
		// unused codes act as reads
		send_beat(make_beat(CMD_SPARE_FIRST, 0, 0, 255, 1));
		send_beat(make_beat(CMD_SPARE_FIRST + 3'd1, 13, 1, 0, 0));
		send_beat(make_beat(CMD_SPARE_LAST, IDX_TOP, IDX_TOP, 255, 1));

		// Random: mostly well-formed net building and stepping, some noise
		while (sb.items_seen < TOTAL_ITEMS) begin
			if (TOTAL_ITEMS - sb.items_seen < QUIET_TAIL)
				idle_odds = 0;
			else
				idle_odds = $urandom_range(0, 3);
			if ($urandom_range(0, 9) == 0)
				run_noise();
			else
				run_scenario();
		end

		// Drain and settle past one full step
		start <= 1'b0;
		guard = 0;
		while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (2 * NUM_TRANS + 8) @(posedge clk);
		sb.flag_missing();

		$display("ran %0d command beats, %0d of them steps", sb.items_seen, sb.steps_seen);
		$display("%0d steps fired something, %0d clipped a token count",
			sb.live_steps, sb.clipped_steps);
		if (sb.errors == 0)
			$display("petri_net_step_engine: match");
		else
			$display("petri_net_step_engine: mismatch");
		$finish;
	end

endmodule
